[rtl/assert_macros.svh]
// Assertion macros of the windowed average unit, included by its controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[rtl/wasr_pkg.sv]
// Package with the shared types and constants of the windowed average unit.
package wasr_pkg;

  // Fixed widths of the channel payload fields.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned AVERAGE_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD1,
    ST_WAIT1,
    ST_CHECK,
    ST_LOAD2,
    ST_WAIT2,
    ST_FINISH
  } wasr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;       // shift the new sample into the window
    logic div_start;  // start a mean computation
    logic check;      // run the spike test and patch the window
    logic out_load;   // capture the result into the output register
  } wasr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;   // divider still iterating
    logic spike;      // new sample lies outside the accepted band
  } wasr_sts_t;

endpackage

[rtl/wasr_if.sv]
// Channel interfaces of the windowed average unit: sample input and result output.
interface wasr_in_if;
  import wasr_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wasr_out_if;
  import wasr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [AVERAGE_W-1:0] average;
  logic                 replaced;

  modport source (output valid, output average, output replaced, input ready);
  modport sink   (input valid, input average, input replaced, output ready);
endinterface

[rtl/windowed_average_spike_reject_unit.sv]
// Top level of the windowed average unit with spike rejection.
//
// The unit takes one unsigned speed sample per transaction on in_i and returns one
// transaction on out_o carrying the truncated mean of the newest stored samples
// (up to WINDOW_LEN of them) and a flag that tells whether the new sample was judged
// a spike. A spike is a sample above twice the mean or below half of it; it is
// replaced in the window by the mean, and the mean is then computed again.
// Both channels use a valid/ready handshake; a transaction completes on a rising
// clock edge where both are high.
// One item is processed at a time. The mean is produced by an iterative divider
// that retires one quotient bit per cycle over N = SAMPLE_BITS + clog2(WINDOW_LEN)
// bits; at the defaults N is 19. An item passes through LOAD1, WAIT1 and CHECK,
// and through LOAD2 and WAIT2 as well when a spike forces the second mean, before
// FINISH loads the result; the next sample is taken from IDLE after that.
// The result sits in an output register, so a new sample is accepted while a
// result still waits. When the receiver stalls, the next finished result holds
// inside the unit until the output register frees, and no further sample is taken.
// Reset is asynchronous and active low; it empties the window, the running sum
// and the fill count, and drops any pending result.
module windowed_average_spike_reject_unit #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wasr_in_if.sink           in_i,
  wasr_out_if.source        out_o
);
  import wasr_pkg::*;

  wasr_cmd_t cmd;
  wasr_sts_t sts;

  // Controller: owns the handshakes and sequences the datapath.
  wasr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: window shift line, running sum, divider and result register.
  wasr_datapath #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sample_i   (in_i.sample),
    .average_o  (out_o.average),
    .replaced_o (out_o.replaced)
  );

endmodule

[rtl/wasr_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module wasr_div #(
  parameter int unsigned NUM_W = 19,
  parameter int unsigned DEN_W = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quotient_o
);
  import wasr_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  // Bring down the next dividend bit and subtract the divisor when it fits.
  assign trial    = {rem_q, quo_q[NUM_W-1]};
  assign ge       = (trial >= {1'b0, divisor_i});
  assign diff     = trial - {1'b0, divisor_i};
  assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= rem_next;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

[rtl/wasr_datapath.sv]
// Datapath: sample window, running sum, fill count, divider and output register.
module wasr_datapath #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wasr_pkg::wasr_cmd_t             cmd_i,
  output wasr_pkg::wasr_sts_t             sts_o,
  input  logic [wasr_pkg::SAMPLE_W-1:0]   sample_i,
  output logic [wasr_pkg::AVERAGE_W-1:0]  average_o,
  output logic                            replaced_o
);
  import wasr_pkg::*;

  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);

  logic [SAMPLE_BITS-1:0] window_q [WINDOW_LEN];
  logic [SUM_W-1:0]       sum_q;
  logic [FILL_W-1:0]      fill_q;
  logic                   spike_q;
  logic [AVERAGE_W-1:0]   average_q;
  logic                   replaced_q;

  logic [SAMPLE_BITS-1:0] smp;
  logic [SUM_W-1:0]       quotient;
  logic [SAMPLE_BITS-1:0] avg;
  logic                   div_busy;
  logic                   too_high;
  logic                   too_low;

  assign smp = SAMPLE_BITS'(sample_i);

  wasr_div #(
    .NUM_W (SUM_W),
    .DEN_W (FILL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (fill_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // The mean never exceeds the largest stored sample, so it fits a sample.
  assign avg = quotient[SAMPLE_BITS-1:0];

  // Spike test against the newest entry, which still holds the raw sample.
  assign too_high = ({1'b0, window_q[0]} > {avg, 1'b0});
  assign too_low  = (window_q[0] < (avg >> 1));

  assign sts_o.div_busy = div_busy;
  assign sts_o.spike    = too_high | too_low;

  // The sum covers every entry; entries beyond the fill count are still zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window_q[i] <= '0;
      end
      sum_q   <= '0;
      fill_q  <= '0;
      spike_q <= 1'b0;
    end else if (cmd_i.push) begin
      for (int i = 1; i < WINDOW_LEN; i++) begin
        window_q[i] <= window_q[i-1];
      end
      window_q[0] <= smp;
      sum_q       <= sum_q + SUM_W'(smp) - SUM_W'(window_q[WINDOW_LEN-1]);
      if (fill_q < FILL_W'(WINDOW_LEN)) begin
        fill_q <= fill_q + FILL_W'(1);
      end
    end else if (cmd_i.check) begin
      spike_q <= sts_o.spike;
      if (sts_o.spike) begin
        window_q[0] <= avg;
        sum_q       <= sum_q - SUM_W'(window_q[0]) + SUM_W'(avg);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      average_q  <= AVERAGE_W'(avg);
      replaced_q <= spike_q;
    end
  end

  assign average_o  = average_q;
  assign replaced_o = replaced_q;

endmodule

[rtl/wasr_ctrl.sv]
// Controller state machine sequencing push, mean, spike test and result hand-off.
`include "assert_macros.svh"

module wasr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wasr_pkg::wasr_cmd_t cmd_o,
  input  wasr_pkg::wasr_sts_t sts_i
);
  import wasr_pkg::*;

  wasr_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOAD1;
        end
      end
      ST_LOAD1: state_d = ST_WAIT1;
      ST_WAIT1: begin
        if (!sts_i.div_busy) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: state_d = sts_i.spike ? ST_LOAD2 : ST_FINISH;
      ST_LOAD2: state_d = ST_WAIT2;
      ST_WAIT2: begin
        if (!sts_i.div_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.push = in_valid_i;
      end
      ST_LOAD1:  cmd_o.div_start = 1'b1;
      ST_CHECK:  cmd_o.check     = 1'b1;
      ST_LOAD2:  cmd_o.div_start = 1'b1;
      ST_FINISH: cmd_o.out_load  = out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_PROP(a_start_busy, clk_i, rst_ni, cmd_o.div_start |=> sts_i.div_busy, "divider did not start")
  `ASSERT_PROP(a_load_valid, clk_i, rst_ni, cmd_o.out_load |=> out_valid_o, "result not presented")
  `ASSERT_PROP(a_one_item, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "second item taken")
  `ASSERT_NEVER(a_push_busy, clk_i, rst_ni, cmd_o.push && sts_i.div_busy, "push during division")

endmodule
